// ----- rtl/oaht_pkg.sv -----
// constants and types shared by the open addressing hash table
// no dependencies
`default_nettype none
package oaht_pkg;
  localparam int CAPACITY_DEF = 256;
  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE = 2'd1;
  localparam logic [1:0] ST_TOMB = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef logic [1:0] slot_state_t;
endpackage
`default_nettype wire

// ----- rtl/open_addressing_hash_table_unit.sv -----
// open addressing hash table: fnv-1a hash, linear probing with tombstones
// depends on oaht_pkg
`default_nettype none
// One request at a time. A request (mode, key, value) is hashed with 32-bit
// FNV-1a, one key byte per cycle through a single shared multiplier, then the
// table is walked by linear probing from hash mod CAPACITY, each slot being
// read from slot memory, then compared, until a matching live key or an empty
// slot ends the walk or every slot has been probed. Insert updates a live key,
// else reuses the first tombstone, else takes the empty slot unless three
// quarters of the slots are in use (status full). Lookup returns the value,
// erase leaves a tombstone. CAPACITY must be a power of two: the start slot
// is the low hash bits and the probe index wraps by overflow.
// Clear is a sweep over the slot state memory. After reset the same sweep
// empties the table before the first request is taken.
// The result sits in an output register; the next request is taken once the
// result is taken.
module open_addressing_hash_table_unit #(
  parameter int CAPACITY = oaht_pkg::CAPACITY_DEF,
  parameter int MAX_KEY_BYTES = oaht_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // mode[1:0], key_bytes[65:2], key_len[69:66], value_in[133:70], zero fill
  input  wire  [135:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // status[1:0], value_out[65:2], key_was_new[66], live_count[75:67], zero fill
  output logic [79:0]  out_tdata
);
  import oaht_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = 8 * MAX_KEY_BYTES;

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // slot memories
  slot_state_t    st_mem [CAPACITY];
  logic [KW-1:0]  key_mem [CAPACITY];
  logic [3:0]     len_mem [CAPACITY];
  logic [31:0]    hash_mem [CAPACITY];
  logic [63:0]    val_mem [CAPACITY];

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [KW-1:0] key_r;
  logic [3:0]    len_r;
  logic [63:0]   value_r;
  logic [31:0]   hash_r;
  logic [3:0]    byte_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] probes_r;
  logic          tomb_r;
  logic [AW-1:0] tomb_at_r;
  logic [CW-1:0] used_r, live_r;
  logic [1:0]    stat_r;
  logic [63:0]   vout_r;
  logic          new_r;
  logic          out_valid_r;

  // registered memory reads
  slot_state_t   rd_st_r;
  logic [KW-1:0] rd_key_r;
  logic [3:0]    rd_len_r;
  logic [31:0]   rd_hash_r;
  logic [63:0]   rd_val_r;

  // input unpack, key masking and length clamp
  logic [1:0]  in_mode;
  logic [63:0] in_key;
  logic [3:0]  in_len, in_len_c;
  logic [KW-1:0] in_key_m;
  always_comb begin
    in_mode = in_tdata[1:0];
    in_key  = in_tdata[65:2];
    in_len  = in_tdata[69:66];
    in_len_c = (in_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : in_len;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      in_key_m[8*i +: 8] = (4'(i) < in_len_c) ? in_key[8*i +: 8] : 8'h00;
    end
  end

  // shared multiplier: one fnv round per cycle
  logic [7:0]  hbyte;
  logic [31:0] hround;
  always_comb begin
    hbyte = key_r[8*byte_r[2:0] +: 8];
    hround = (hash_r ^ {24'd0, hbyte}) * FNV_PRIME;
  end

  logic key_match;
  assign key_match = (rd_st_r == ST_LIVE) && (rd_len_r == len_r) &&
                     (rd_hash_r == hash_r) && (rd_key_r == key_r);

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'd0, 9'(live_r), new_r, vout_r, stat_r};

  logic full_load;
  assign full_load = ({used_r, 2'b00}) >= (CW+2)'(3 * CAPACITY);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (idx_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = (in_mode == MODE_CLEAR) ? S_INIT : S_HASH;
        end
      end
      S_HASH: begin
        if (byte_r == len_r) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (rd_st_r == ST_EMPTY || key_match ||
            probes_r == CW'(CAPACITY - 1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // decision at end of walk, registered into S_DONE
  logic found_r, empty_r;

  // single write port: state sweep in S_INIT, insert or erase commit in S_DONE
  logic          cm_st, cm_entry, cm_val;
  slot_state_t   cm_st_val;
  logic [AW-1:0] cm_addr;
  always_comb begin
    cm_st = 1'b0; cm_entry = 1'b0; cm_val = 1'b0;
    cm_st_val = ST_LIVE; cm_addr = idx_r;
    if (state_r == S_INIT) begin
      cm_st = 1'b1; cm_st_val = ST_EMPTY;
    end else if (state_r == S_DONE) begin
      if (mode_r == MODE_INSERT) begin
        if (found_r) begin
          cm_val = 1'b1;
        end else if (tomb_r) begin
          cm_addr = tomb_at_r; cm_st = 1'b1; cm_entry = 1'b1;
        end else if (empty_r && !full_load) begin
          cm_st = 1'b1; cm_entry = 1'b1;
        end
      end else if (mode_r == MODE_ERASE && found_r && used_r != '0) begin
        cm_st = 1'b1; cm_st_val = ST_TOMB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm_st) st_mem[cm_addr] <= cm_st_val;
    if (cm_entry) begin
      key_mem[cm_addr] <= key_r;
      len_mem[cm_addr] <= len_r;
      hash_mem[cm_addr] <= hash_r;
    end
    if (cm_entry || cm_val) val_mem[cm_addr] <= value_r;
    rd_st_r   <= st_mem[idx_r];
    rd_key_r  <= key_mem[idx_r];
    rd_len_r  <= len_mem[idx_r];
    rd_hash_r <= hash_mem[idx_r];
    rd_val_r  <= val_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      idx_r <= '0;
      used_r <= '0;
      live_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT: idx_r <= idx_r + 1'b1;
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r <= in_mode;
            key_r <= in_key_m;
            len_r <= in_len_c;
            value_r <= in_tdata[133:70];
            hash_r <= FNV_BASIS;
            byte_r <= '0;
            idx_r <= '0;
            stat_r <= STAT_DONE;
            vout_r <= '0;
            new_r <= 1'b0;
            if (in_mode == MODE_CLEAR) begin
              used_r <= '0;
              live_r <= '0;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_HASH: begin
          if (byte_r == len_r) begin
            idx_r <= hash_r[AW-1:0];
            probes_r <= '0;
            tomb_r <= 1'b0;
            found_r <= 1'b0;
            empty_r <= 1'b0;
          end else begin
            hash_r <= hround;
            byte_r <= byte_r + 1'b1;
          end
        end
        S_READ: ;
        S_CMP: begin
          if (rd_st_r == ST_EMPTY) begin
            empty_r <= 1'b1;
          end else if (key_match) begin
            found_r <= 1'b1;
          end else begin
            if (rd_st_r == ST_TOMB && !tomb_r) begin
              tomb_r <= 1'b1;
              tomb_at_r <= idx_r;
            end
            if (probes_r != CW'(CAPACITY - 1)) begin
              idx_r <= idx_r + 1'b1;
              probes_r <= probes_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (mode_r == MODE_INSERT) begin
            if (!found_r) begin
              if (tomb_r) begin
                live_r <= live_r + 1'b1; new_r <= 1'b1;
              end else if (empty_r && !full_load) begin
                live_r <= live_r + 1'b1; used_r <= used_r + 1'b1; new_r <= 1'b1;
              end else begin
                stat_r <= STAT_FULL;
              end
            end
          end else if (used_r == '0 || !found_r) begin
            stat_r <= STAT_NOT_FOUND;
          end else if (mode_r == MODE_LOOKUP) begin
            vout_r <= rd_val_r;
          end else begin
            live_r <= live_r - 1'b1;
          end
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
